// ===== rtl/pidl_pkg.sv =====
// Shared types, codes and defaults for the positional insert/delete list.
package pidl_pkg;

    localparam int unsigned CAPACITY_DEF   = 16;
    localparam int unsigned ITEM_WIDTH_DEF = 32;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LEN_W    = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_PEEK   = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   position;
        logic [DATA_W-1:0]  item_data;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        t_status            status;
        logic [LEN_W-1:0]   length;
        logic               is_full;
        logic               is_empty;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

// ===== rtl/pidl_ctrl.sv =====
// Controller: accepts a transfer, schedules execution, tracks the output register.
module pidl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pidl_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_load;

    assign can_load = !r_out_valid || i_out_ready;

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (can_load) begin
                    o_cmd.execute = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.execute) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/pidl_dp.sv =====
// Datapath: row of entry cells, count, operation decode and result register.
module pidl_dp #(
    parameter int unsigned CAPACITY   = pidl_pkg::CAPACITY_DEF,
    parameter int unsigned ITEM_WIDTH = pidl_pkg::ITEM_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pidl_pkg::t_dp_cmd   i_cmd,
    input  pidl_pkg::t_in_item  i_in_data,
    output pidl_pkg::t_out_item o_out_data
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned PW = (CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W;

    logic [ITEM_WIDTH-1:0] r_entries [CAPACITY];
    logic [ITEM_WIDTH-1:0] n_entries [CAPACITY];
    logic [CW-1:0]         r_count, n_count;
    pidl_pkg::t_kind       r_kind;
    logic [pidl_pkg::POS_W-1:0] r_pos;
    logic [ITEM_WIDTH-1:0] r_data;
    pidl_pkg::t_out_item   r_out, n_out;

    logic [PW-1:0]         pos_ext;
    logic [PW-1:0]         cnt_ext;
    logic                  is_full_now;
    logic                  is_empty_now;
    logic                  do_ins;
    logic                  do_del;
    logic [ITEM_WIDTH-1:0] peek_word;
    logic [63:0]           peek_wide;

    assign pos_ext      = PW'(r_pos);
    assign cnt_ext      = PW'(r_count);
    assign is_full_now  = (r_count == CW'(CAPACITY));
    assign is_empty_now = (r_count == '0);
    assign peek_word    = r_entries[pos_ext[IW-1:0]];
    assign peek_wide    = 64'(peek_word);

    always_comb begin
        n_count         = r_count;
        do_ins          = 1'b0;
        do_del          = 1'b0;
        n_out.read_data = '0;
        n_out.status    = pidl_pkg::STAT_OK;
        case (r_kind)
            pidl_pkg::KIND_INSERT: begin
                if (is_full_now) begin
                    n_out.status = pidl_pkg::STAT_FULL;
                end else if (pos_ext > cnt_ext) begin
                    n_out.status = pidl_pkg::STAT_RANGE;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            pidl_pkg::KIND_DELETE: begin
                if (is_empty_now) begin
                    n_out.status = pidl_pkg::STAT_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    n_out.status = pidl_pkg::STAT_RANGE;
                end else begin
                    do_del  = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            pidl_pkg::KIND_PEEK: begin
                if (is_empty_now) begin
                    n_out.status = pidl_pkg::STAT_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    n_out.status = pidl_pkg::STAT_RANGE;
                end else begin
                    n_out.read_data = peek_wide[pidl_pkg::DATA_W-1:0];
                end
            end
            pidl_pkg::KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.length   = pidl_pkg::LEN_W'(n_count);
        n_out.is_full  = (n_count == CW'(CAPACITY));
        n_out.is_empty = (n_count == '0);
    end

    // each cell takes its own word, the new item, its lower neighbor's or its upper neighbor's
    always_comb begin
        for (int unsigned i = 0; i < CAPACITY; i++) begin
            n_entries[i] = r_entries[i];
            if (do_ins) begin
                if (PW'(i) == pos_ext) begin
                    n_entries[i] = r_data;
                end else if ((i > 0) && (PW'(i) > pos_ext)) begin
                    n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
                end
            end else if (do_del) begin
                if ((i + 1 < CAPACITY) && (PW'(i) >= pos_ext)) begin
                    n_entries[i] = r_entries[(i + 1 < CAPACITY) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            for (int unsigned i = 0; i < CAPACITY; i++) begin
                r_entries[i] <= n_entries[i];
            end
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_in_data.kind;
            r_pos  <= i_in_data.position;
            r_data <= 64'(i_in_data.item_data) >> 0 == 0 ? '0 :
                      ITEM_WIDTH'(64'(i_in_data.item_data));
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== rtl/positional_insert_delete_list.sv =====
// Top level: ordered list with insert, delete, peek and clear at a position.
// A transfer is captured on acceptance, then executed into the result register (capture, then execute).
// A new item is taken only once the last one has executed; the next item is taken while a result waits.
// The execute step stalls only while the output register still holds an untaken result.
// Reset (synchronous, active low) empties the list and drops any pending result.
module positional_insert_delete_list #(
    parameter int unsigned CAPACITY   = pidl_pkg::CAPACITY_DEF,
    parameter int unsigned ITEM_WIDTH = pidl_pkg::ITEM_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pidl_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pidl_pkg::t_out_item o_out_data
);

    pidl_pkg::t_dp_cmd cmd;

    pidl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    pidl_dp #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

// ===== tb/sv/positional_insert_delete_list_test.sv =====
// Self-checking testbench for the positional insert/delete list: directed table, then random ops.
`timescale 1ns / 1ps

module positional_insert_delete_list_test;

    localparam int LIST_CAP = int'(pidl_pkg::CAPACITY_DEF);
    localparam int RANDOM_OPS = 850;
    localparam int HOLD_OFF_CYCLES = 120;

    typedef enum logic [1:0] {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } t_load_phase;

    typedef struct packed {
        pidl_pkg::t_in_item  op;
        logic [7:0]          reps;
        logic                known;
        pidl_pkg::t_out_item result;
    } t_script_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    pidl_pkg::t_in_item  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    pidl_pkg::t_out_item o_out_data;

    logic [pidl_pkg::DATA_W-1:0] list_entries [LIST_CAP];
    int                          list_count = 0;
    pidl_pkg::t_out_item         due_results [$];
    t_script_row                 script_rows [$];
    int                          mismatch_count = 0;
    int                          ops_accepted = 0;
    int                          burst_left = 0;
    bit                          flood = 1'b0;

    positional_insert_delete_list u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic pidl_pkg::t_out_item outcome(input pidl_pkg::t_status st, input int len);
        pidl_pkg::t_out_item r;
        r = '0;
        r.status = st;
        r.length = pidl_pkg::LEN_W'(len);
        r.is_full = (len == LIST_CAP);
        r.is_empty = (len == 0);
        return r;
    endfunction

    function automatic pidl_pkg::t_out_item apply_list_op(input pidl_pkg::t_in_item it);
        pidl_pkg::t_out_item r;
        int                  p;
        r = '0;
        r.status = pidl_pkg::STAT_OK;
        p = int'(it.position);
        case (it.kind)
            pidl_pkg::KIND_INSERT: begin
                if (list_count >= LIST_CAP) begin
                    r.status = pidl_pkg::STAT_FULL;
                end else if (p > list_count) begin
                    r.status = pidl_pkg::STAT_RANGE;
                end else begin
                    for (int i = list_count; i > p; i--)
                        list_entries[i] = list_entries[i-1];
                    list_entries[p] = it.item_data;
                    list_count++;
                end
            end
            pidl_pkg::KIND_DELETE: begin
                if (list_count == 0) begin
                    r.status = pidl_pkg::STAT_EMPTY;
                end else if (p >= list_count) begin
                    r.status = pidl_pkg::STAT_RANGE;
                end else begin
                    list_count--;
                    for (int i = p; i < list_count; i++)
                        list_entries[i] = list_entries[i+1];
                end
            end
            pidl_pkg::KIND_PEEK: begin
                if (list_count == 0) begin
                    r.status = pidl_pkg::STAT_EMPTY;
                end else if (p >= list_count) begin
                    r.status = pidl_pkg::STAT_RANGE;
                end else begin
                    r.read_data = list_entries[p];
                end
            end
            default: begin
                list_count = 0;
            end
        endcase
        r.length = pidl_pkg::LEN_W'(list_count);
        r.is_full = (list_count == LIST_CAP);
        r.is_empty = (list_count == 0);
        return r;
    endfunction

    function automatic pidl_pkg::t_in_item next_list_op(input t_load_phase ph);
        pidl_pkg::t_in_item it;
        int                 roll;
        it.item_data = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            it.kind = pidl_pkg::KIND_CLEAR;
        else if ((ph == PH_FILL && roll < 70) || (ph == PH_DRAIN && roll < 20) ||
                 (ph == PH_MIXED && roll < 40))
            it.kind = pidl_pkg::KIND_INSERT;
        else if ((ph == PH_FILL && roll < 85) || (ph == PH_DRAIN && roll < 40) ||
                 (ph == PH_MIXED && roll < 70))
            it.kind = pidl_pkg::KIND_PEEK;
        else
            it.kind = pidl_pkg::KIND_DELETE;
        if ($urandom_range(0, 9) == 0)
            it.position = pidl_pkg::POS_W'($urandom_range(0, 31));
        else if (it.kind == pidl_pkg::KIND_INSERT)
            it.position = pidl_pkg::POS_W'($urandom_range(0, list_count));
        else if (list_count > 0)
            it.position = pidl_pkg::POS_W'($urandom_range(0, list_count - 1));
        else
            it.position = pidl_pkg::POS_W'($urandom_range(0, 31));
        return it;
    endfunction

    task automatic add_row(input pidl_pkg::t_kind k, input int pos,
                           input logic [pidl_pkg::DATA_W-1:0] d,
                           input int reps, input bit known, input pidl_pkg::t_out_item res);
        t_script_row row;
        row.op.kind = k;
        row.op.position = pidl_pkg::POS_W'(pos);
        row.op.item_data = d;
        row.reps = 8'(reps);
        row.known = known;
        row.result = res;
        script_rows.push_back(row);
    endtask

    task automatic pace();
        int gap;
        if (flood)
            return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 12);
        gap = $urandom_range(1, 8);
        i_in_valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic offer(input pidl_pkg::t_in_item it, input bit known,
                         input pidl_pkg::t_out_item res);
        pidl_pkg::t_out_item predicted;
        i_in_data <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = apply_list_op(it);
        due_results.push_back(known ? res : predicted);
        ops_accepted++;
    endtask

    task automatic report_mismatch(input string field, input logic [pidl_pkg::DATA_W-1:0] want,
                                   input logic [pidl_pkg::DATA_W-1:0] got);
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        pidl_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result", '0,
                                pidl_pkg::DATA_W'(o_out_data.status));
            end else begin
                want = due_results.pop_front();
                if (o_out_data.read_data !== want.read_data)
                    report_mismatch("read_data", want.read_data, o_out_data.read_data);
                if (o_out_data.status !== want.status)
                    report_mismatch("status", pidl_pkg::DATA_W'(want.status),
                                    pidl_pkg::DATA_W'(o_out_data.status));
                if (o_out_data.length !== want.length)
                    report_mismatch("length", pidl_pkg::DATA_W'(want.length),
                                    pidl_pkg::DATA_W'(o_out_data.length));
                if (o_out_data.is_full !== want.is_full)
                    report_mismatch("is_full", pidl_pkg::DATA_W'(want.is_full),
                                    pidl_pkg::DATA_W'(o_out_data.is_full));
                if (o_out_data.is_empty !== want.is_empty)
                    report_mismatch("is_empty", pidl_pkg::DATA_W'(want.is_empty),
                                    pidl_pkg::DATA_W'(o_out_data.is_empty));
            end
        end
    end

    // receiver: stretches of stall patterns, plus long hold-offs that back up the input
    initial begin
        int          holdoffs_done;
        int          mode;
        int          n;
        logic [7:0]  pattern;
        holdoffs_done = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (holdoffs_done < 2 && ops_accepted >= (holdoffs_done == 0 ? 250 : 600)) begin
                flood = 1'b1;
                @(posedge i_clk);
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                flood = 1'b0;
                holdoffs_done++;
            end
            mode = $urandom_range(0, 2);
            n = $urandom_range(10, 60);
            pattern = 8'($urandom);
            for (int c = 0; c < n; c++) begin
                @(posedge i_clk);
                if (mode == 0)
                    i_out_ready <= 1'b1;
                else if (mode == 1)
                    i_out_ready <= pattern[c % 8];
                else
                    i_out_ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin
        t_load_phase         phase;
        int                  phase_left;
        pidl_pkg::t_out_item none;
        none = '0;

        add_row(pidl_pkg::KIND_PEEK, 0, 32'h0, 1, 1, outcome(pidl_pkg::STAT_EMPTY, 0));
        add_row(pidl_pkg::KIND_DELETE, 0, 32'h0, 1, 1, outcome(pidl_pkg::STAT_EMPTY, 0));
        add_row(pidl_pkg::KIND_INSERT, 1, 32'hDEAD_BEEF, 1, 1, outcome(pidl_pkg::STAT_RANGE, 0));
        add_row(pidl_pkg::KIND_INSERT, 0, 32'hFFFF_FFFF, 1, 1, outcome(pidl_pkg::STAT_OK, 1));
        add_row(pidl_pkg::KIND_INSERT, 0, 32'h0, 1, 1, outcome(pidl_pkg::STAT_OK, 2));
        add_row(pidl_pkg::KIND_PEEK, 1, 32'h0, 1, 0, none);
        add_row(pidl_pkg::KIND_PEEK, 2, 32'h0, 1, 1, outcome(pidl_pkg::STAT_RANGE, 2));
        add_row(pidl_pkg::KIND_INSERT, 1, 32'h8000_0001, 13, 0, none);
        add_row(pidl_pkg::KIND_INSERT, 15, 32'h5A5A_A5A5, 1, 1, outcome(pidl_pkg::STAT_OK, 16));
        add_row(pidl_pkg::KIND_INSERT, 0, 32'h1234_5678, 1, 1, outcome(pidl_pkg::STAT_FULL, 16));
        add_row(pidl_pkg::KIND_PEEK, 15, 32'h0, 1, 0, none);
        add_row(pidl_pkg::KIND_PEEK, 16, 32'h0, 1, 1, outcome(pidl_pkg::STAT_RANGE, 16));
        add_row(pidl_pkg::KIND_DELETE, 16, 32'h0, 1, 1, outcome(pidl_pkg::STAT_RANGE, 16));
        add_row(pidl_pkg::KIND_DELETE, 0, 32'h0, 1, 0, none);
        add_row(pidl_pkg::KIND_INSERT, 31, 32'h0, 1, 1, outcome(pidl_pkg::STAT_RANGE, 15));
        add_row(pidl_pkg::KIND_PEEK, 0, 32'h0, 1, 0, none);
        add_row(pidl_pkg::KIND_CLEAR, 31, 32'hFFFF_FFFF, 1, 1, outcome(pidl_pkg::STAT_OK, 0));
        add_row(pidl_pkg::KIND_PEEK, 0, 32'h0, 1, 1, outcome(pidl_pkg::STAT_EMPTY, 0));
        add_row(pidl_pkg::KIND_DELETE, 31, 32'h0, 1, 1, outcome(pidl_pkg::STAT_EMPTY, 0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script_rows[r]) begin
            for (int k = 0; k < script_rows[r].reps; k++) begin
                pace();
                offer(script_rows[r].op, script_rows[r].known, script_rows[r].result);
            end
        end

        phase_left = 0;
        phase = PH_FILL;
        for (int k = 0; k < RANDOM_OPS; k++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0: phase = PH_FILL;
                    1: phase = PH_DRAIN;
                    default: phase = PH_MIXED;
                endcase
                phase_left = $urandom_range(30, 80);
            end
            phase_left--;
            pace();
            offer(next_list_op(phase), 1'b0, none);
        end
        i_in_valid <= 1'b0;

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pidl_pkg.sv
rtl/pidl_ctrl.sv
rtl/pidl_dp.sv
rtl/positional_insert_delete_list.sv
tb/sv/positional_insert_delete_list_test.sv
